@@ hdl/csrft_pkg.sv @@
// ----------------------------------------------------------------------------
// csrft_pkg
// Shared codes, masks and CSR addresses for the RV64 CSR file with traps.
// ----------------------------------------------------------------------------
`default_nettype none

package csrft_pkg;

  // Operation kinds.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TRAP  = 2'd2,
    KIND_RET   = 2'd3
  } kind_e;

  // Error codes.
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_PRIV   = 3'd1;
  localparam logic [2:0] ERR_UNIMPL = 3'd2;
  localparam logic [2:0] ERR_RDONLY = 3'd3;
  localparam logic [2:0] ERR_CNT    = 3'd4;

  // Privilege modes.
  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_R = 2'd2;
  localparam logic [1:0] PRIV_M = 2'd3;

  // CSR addresses.
  localparam logic [11:0] CSR_SSTATUS    = 12'h100;
  localparam logic [11:0] CSR_SIE        = 12'h104;
  localparam logic [11:0] CSR_STVEC      = 12'h105;
  localparam logic [11:0] CSR_SCOUNTEREN = 12'h106;
  localparam logic [11:0] CSR_SSCRATCH   = 12'h140;
  localparam logic [11:0] CSR_SEPC       = 12'h141;
  localparam logic [11:0] CSR_SCAUSE     = 12'h142;
  localparam logic [11:0] CSR_STVAL      = 12'h143;
  localparam logic [11:0] CSR_SIP        = 12'h144;
  localparam logic [11:0] CSR_SATP       = 12'h180;
  localparam logic [11:0] CSR_MSTATUS    = 12'h300;
  localparam logic [11:0] CSR_MISA       = 12'h301;
  localparam logic [11:0] CSR_MEDELEG    = 12'h302;
  localparam logic [11:0] CSR_MIDELEG    = 12'h303;
  localparam logic [11:0] CSR_MIE        = 12'h304;
  localparam logic [11:0] CSR_MTVEC      = 12'h305;
  localparam logic [11:0] CSR_MCOUNTEREN = 12'h306;
  localparam logic [11:0] CSR_MSCRATCH   = 12'h340;
  localparam logic [11:0] CSR_MEPC       = 12'h341;
  localparam logic [11:0] CSR_MCAUSE     = 12'h342;
  localparam logic [11:0] CSR_MTVAL      = 12'h343;
  localparam logic [11:0] CSR_MIP        = 12'h344;
  localparam logic [11:0] CSR_MCYCLE     = 12'hB00;
  localparam logic [11:0] CSR_MINSTRET   = 12'hB02;
  localparam logic [11:0] CSR_CYCLE      = 12'hC00;
  localparam logic [11:0] CSR_INSTRET    = 12'hC02;
  localparam logic [11:0] CSR_MHARTID    = 12'hF14;

  // Constant values and masks.
  localparam logic [63:0] MISA_VALUE   = (64'd2 << 62) | (64'd1 << 8);
  localparam logic [63:0] SATP_MODE    = 64'hF << 60;
  localparam logic [63:0] SATP_SV39    = 64'h8 << 60;
  localparam logic [63:0] ALIGN_MASK   = ~64'h3;
  localparam logic [63:0] ST_UXL64     = 64'd2 << 32;
  localparam logic [63:0] ST_SXL64     = 64'd2 << 34;
  localparam logic [63:0] SSTATUS_MASK = 64'h000C_0122;
  localparam logic [63:0] MSTATUS_MASK = 64'h007E_19AA;
  localparam logic [11:0] INT_S_MASK   = 12'h222;
  localparam logic [11:0] INT_SSIP     = 12'h002;
  localparam logic [11:0] INT_ALL_MASK = 12'hAAA;
  localparam logic [15:0] EXC_DELEG    = 16'hB3FF;

  // Status bit positions.
  localparam int unsigned SB_SIE  = 1;
  localparam int unsigned SB_MIE  = 3;
  localparam int unsigned SB_SPIE = 5;
  localparam int unsigned SB_MPIE = 7;
  localparam int unsigned SB_SPP  = 8;
  localparam int unsigned SB_MPP  = 11;
  localparam int unsigned SB_MPRV = 17;

endpackage

`default_nettype wire

@@ hdl/rv64_csr_file_with_traps_top.sv @@
// ----------------------------------------------------------------------------
// rv64_csr_file_with_traps_top
// RV64 machine and supervisor CSR file with trap entry and trap return.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o kind, csr_address, operand_value,
//                                           privilege, trap_cause, trap_pc,
//                                           return_to_machine
// out      output     out_valid_o/out_stall_i read_data, error_code,
//                                           new_privilege, target_pc
//
// One item is taken every cycle unless stalled; its result shows next cycle.
// The CSR state updates at the accepting edge, so the next item sees it.
// Reset clears all CSR state and the output valid flag.
// When the result register is full and stalled, the input is stalled too.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64_csr_file_with_traps_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [11:0] csr_address_i,
  input  wire logic [63:0] operand_value_i,
  input  wire logic [1:0]  privilege_i,
  input  wire logic [63:0] trap_cause_i,
  input  wire logic [63:0] trap_pc_i,
  input  wire logic        return_to_machine_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      read_data_o,
  output logic [2:0]       error_code_o,
  output logic [1:0]       new_privilege_o,
  output logic [63:0]      target_pc_o
);
  import csrft_pkg::*;

  // CSR state.
  logic [63:0] mstatus_q, mstatus_d;
  logic [15:0] medeleg_q, medeleg_d;
  logic [11:0] mideleg_q, mideleg_d, mie_q, mie_d, mip_q, mip_d;
  logic [63:0] mtvec_q, mtvec_d, mscratch_q, mscratch_d, mepc_q, mepc_d;
  logic [63:0] mcause_q, mcause_d, mtval_q, mtval_d;
  logic [2:0]  mcounteren_q, mcounteren_d, scounteren_q, scounteren_d;
  logic [63:0] stvec_q, stvec_d, sscratch_q, sscratch_d, sepc_q, sepc_d;
  logic [63:0] scause_q, scause_d, stval_q, stval_d, satp_q, satp_d;
  logic [63:0] cycle_q, cycle_d, instret_q, instret_d;

  // Result register.
  logic        out_valid_q;
  logic [63:0] rd_q, rd_d, tpc_q, tpc_d;
  logic [2:0]  err_q, err_d;
  logic [1:0]  np_q, np_d;

  logic        accept;
  logic [1:0]  priv;
  logic        exists, is_wr;
  logic [2:0]  cbit;
  logic [63:0] csr_val, m, mst;
  logic [1:0]  mpp;
  logic        deleg;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign priv       = (privilege_i == PRIV_R) ? PRIV_U : privilege_i;
  assign is_wr      = (kind_i == KIND_WRITE);

  // Implemented address set.
  always_comb begin
    case (csr_address_i)
      CSR_SSTATUS, CSR_SIE, CSR_STVEC, CSR_SCOUNTEREN, CSR_SSCRATCH, CSR_SEPC,
      CSR_SCAUSE, CSR_STVAL, CSR_SIP, CSR_SATP, CSR_MSTATUS, CSR_MISA,
      CSR_MEDELEG, CSR_MIDELEG, CSR_MIE, CSR_MTVEC, CSR_MCOUNTEREN,
      CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL, CSR_MIP, CSR_MCYCLE,
      CSR_MINSTRET, CSR_CYCLE, CSR_INSTRET, CSR_MHARTID: exists = 1'b1;
      default: exists = 1'b0;
    endcase
  end

  // Read value of the addressed CSR.
  always_comb begin
    case (csr_address_i)
      CSR_SSTATUS:    csr_val = (mstatus_q & SSTATUS_MASK) | ST_UXL64;
      CSR_SIE:        csr_val = {52'd0, mie_q & mideleg_q & INT_S_MASK};
      CSR_STVEC:      csr_val = stvec_q;
      CSR_SCOUNTEREN: csr_val = {61'd0, scounteren_q};
      CSR_SSCRATCH:   csr_val = sscratch_q;
      CSR_SEPC:       csr_val = sepc_q;
      CSR_SCAUSE:     csr_val = scause_q;
      CSR_STVAL:      csr_val = stval_q;
      CSR_SIP:        csr_val = {52'd0, mip_q & mideleg_q & INT_S_MASK};
      CSR_SATP:       csr_val = satp_q;
      CSR_MSTATUS:    csr_val = mstatus_q | ST_UXL64 | ST_SXL64;
      CSR_MISA:       csr_val = MISA_VALUE;
      CSR_MEDELEG:    csr_val = {48'd0, medeleg_q};
      CSR_MIDELEG:    csr_val = {52'd0, mideleg_q};
      CSR_MIE:        csr_val = {52'd0, mie_q};
      CSR_MTVEC:      csr_val = mtvec_q;
      CSR_MCOUNTEREN: csr_val = {61'd0, mcounteren_q};
      CSR_MSCRATCH:   csr_val = mscratch_q;
      CSR_MEPC:       csr_val = mepc_q;
      CSR_MCAUSE:     csr_val = mcause_q;
      CSR_MTVAL:      csr_val = mtval_q;
      CSR_MIP:        csr_val = {52'd0, mip_q};
      CSR_MCYCLE, CSR_CYCLE:     csr_val = cycle_q;
      CSR_MINSTRET, CSR_INSTRET: csr_val = instret_q;
      default:        csr_val = 64'd0;
    endcase
  end

  // Access check in priority order.
  always_comb begin
    cbit = (csr_address_i == CSR_CYCLE)   ? 3'b001 :
           (csr_address_i == CSR_INSTRET) ? 3'b100 : 3'b000;
    if (priv < csr_address_i[9:8]) err_d = ERR_PRIV;
    else if (!exists) err_d = ERR_UNIMPL;
    else if (is_wr && csr_address_i[11:10] == 2'b11) err_d = ERR_RDONLY;
    else if (!is_wr && cbit != 3'b000 && priv != PRIV_M &&
             (((mcounteren_q & cbit) == 3'b000) ||
              (priv == PRIV_U && (scounteren_q & cbit) == 3'b000)))
      err_d = ERR_CNT;
    else err_d = ERR_OK;
  end

  // Next state and result.
  always_comb begin
    mstatus_d = mstatus_q;     medeleg_d = medeleg_q;   mideleg_d = mideleg_q;
    mie_d = mie_q;             mip_d = mip_q;           mtvec_d = mtvec_q;
    mcounteren_d = mcounteren_q; mscratch_d = mscratch_q; mepc_d = mepc_q;
    mcause_d = mcause_q;       mtval_d = mtval_q;       stvec_d = stvec_q;
    scounteren_d = scounteren_q; sscratch_d = sscratch_q; sepc_d = sepc_q;
    scause_d = scause_q;       stval_d = stval_q;       satp_d = satp_q;
    cycle_d = cycle_q;         instret_d = instret_q;
    rd_d = 64'd0; np_d = PRIV_U; tpc_d = 64'd0;
    m = 64'd0; mst = mstatus_q; mpp = mstatus_q[SB_MPP +: 2];
    deleg = (priv != PRIV_M) && (trap_cause_i < 64'd16) &&
            medeleg_q[trap_cause_i[3:0]];
    case (kind_i)
      KIND_READ: begin
        if (err_d == ERR_OK) rd_d = csr_val;
      end
      KIND_WRITE: begin
        if (err_d == ERR_OK) begin
          case (csr_address_i)
            CSR_SSTATUS: mstatus_d = (mstatus_q & ~SSTATUS_MASK) |
                                     (operand_value_i & SSTATUS_MASK);
            CSR_SIE: mie_d = (mie_q & ~(mideleg_q & INT_S_MASK)) |
                             (operand_value_i[11:0] & mideleg_q & INT_S_MASK);
            CSR_STVEC:      stvec_d = operand_value_i & ALIGN_MASK;
            CSR_SCOUNTEREN: scounteren_d = operand_value_i[2:0];
            CSR_SSCRATCH:   sscratch_d = operand_value_i;
            CSR_SEPC:       sepc_d = operand_value_i & ALIGN_MASK;
            CSR_SCAUSE:     scause_d = operand_value_i;
            CSR_STVAL:      stval_d = operand_value_i;
            CSR_SIP: mip_d = (mip_q & ~(mideleg_q & INT_SSIP)) |
                             (operand_value_i[11:0] & mideleg_q & INT_SSIP);
            CSR_SATP: begin
              if ((operand_value_i & SATP_MODE) == 64'd0) satp_d = 64'd0;
              else if ((operand_value_i & SATP_MODE) == SATP_SV39)
                satp_d = operand_value_i;
            end
            CSR_MSTATUS: begin
              m = operand_value_i & MSTATUS_MASK;
              if (m[SB_MPP +: 2] == PRIV_R) m[SB_MPP +: 2] = PRIV_U;
              mstatus_d = m;
            end
            CSR_MEDELEG:    medeleg_d = operand_value_i[15:0] & EXC_DELEG;
            CSR_MIDELEG:    mideleg_d = operand_value_i[11:0] & INT_S_MASK;
            CSR_MIE:        mie_d = operand_value_i[11:0] & INT_ALL_MASK;
            CSR_MTVEC:      mtvec_d = operand_value_i & ALIGN_MASK;
            CSR_MCOUNTEREN: mcounteren_d = operand_value_i[2:0];
            CSR_MSCRATCH:   mscratch_d = operand_value_i;
            CSR_MEPC:       mepc_d = operand_value_i & ALIGN_MASK;
            CSR_MCAUSE:     mcause_d = operand_value_i;
            CSR_MTVAL:      mtval_d = operand_value_i;
            CSR_MIP:        mip_d = operand_value_i[11:0] & INT_ALL_MASK;
            CSR_MCYCLE:     cycle_d = operand_value_i;
            CSR_MINSTRET:   instret_d = operand_value_i;
            default: ;
          endcase
        end
      end
      KIND_TRAP: begin
        if (deleg) begin
          mst[SB_SPIE] = mstatus_q[SB_SIE];
          mst[SB_SIE]  = 1'b0;
          mst[SB_SPP]  = (priv == PRIV_S);
          sepc_d   = trap_pc_i & ALIGN_MASK;
          scause_d = trap_cause_i;
          stval_d  = operand_value_i;
          np_d  = PRIV_S;
          tpc_d = stvec_q & ALIGN_MASK;
        end else begin
          mst[SB_MPIE] = mstatus_q[SB_MIE];
          mst[SB_MIE]  = 1'b0;
          mst[SB_MPP +: 2] = priv;
          mepc_d   = trap_pc_i & ALIGN_MASK;
          mcause_d = trap_cause_i;
          mtval_d  = operand_value_i;
          np_d  = PRIV_M;
          tpc_d = mtvec_q & ALIGN_MASK;
        end
        mstatus_d = mst;
      end
      default: begin
        if (!return_to_machine_i) begin
          np_d = mstatus_q[SB_SPP] ? PRIV_S : PRIV_U;
          mst[SB_SIE]  = mstatus_q[SB_SPIE];
          mst[SB_SPIE] = 1'b1;
          mst[SB_SPP]  = 1'b0;
          mst[SB_MPRV] = 1'b0;
          tpc_d = sepc_q;
        end else begin
          np_d = (mpp == PRIV_M) ? PRIV_M : (mpp == PRIV_S) ? PRIV_S : PRIV_U;
          mst[SB_MIE]  = mstatus_q[SB_MPIE];
          mst[SB_MPIE] = 1'b1;
          mst[SB_MPP +: 2] = PRIV_U;
          if (mpp != PRIV_M) mst[SB_MPRV] = 1'b0;
          tpc_d = mepc_q;
        end
        mstatus_d = mst;
      end
    endcase
  end

  // CSR state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstatus_q <= '0; medeleg_q <= '0; mideleg_q <= '0; mie_q <= '0;
      mip_q <= '0; mtvec_q <= '0; mcounteren_q <= '0; mscratch_q <= '0;
      mepc_q <= '0; mcause_q <= '0; mtval_q <= '0; stvec_q <= '0;
      scounteren_q <= '0; sscratch_q <= '0; sepc_q <= '0; scause_q <= '0;
      stval_q <= '0; satp_q <= '0; cycle_q <= '0; instret_q <= '0;
    end else if (accept) begin
      mstatus_q <= mstatus_d; medeleg_q <= medeleg_d; mideleg_q <= mideleg_d;
      mie_q <= mie_d; mip_q <= mip_d; mtvec_q <= mtvec_d;
      mcounteren_q <= mcounteren_d; mscratch_q <= mscratch_d;
      mepc_q <= mepc_d; mcause_q <= mcause_d; mtval_q <= mtval_d;
      stvec_q <= stvec_d; scounteren_q <= scounteren_d;
      sscratch_q <= sscratch_d; sepc_q <= sepc_d; scause_q <= scause_d;
      stval_q <= stval_d; satp_q <= satp_d; cycle_q <= cycle_d;
      instret_q <= instret_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload; error only reported for CSR operations.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= rd_d;
      err_q <= (kind_i == KIND_READ || kind_i == KIND_WRITE) ? err_d : ERR_OK;
      np_q  <= np_d;
      tpc_q <= tpc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rd_q;
  assign error_code_o    = err_q;
  assign new_privilege_o = np_q;
  assign target_pc_o     = tpc_q;

`ifndef NO_ASSERTIONS
  // Reserved MPP encoding never reaches the status register.
  a_mpp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mstatus_q[SB_MPP +: 2] != PRIV_R) else $error("reserved MPP stored");
  // Input is stalled only when a result is held.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q) else $error("stall without result");
  // A held result does not change while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(target_pc_o) && $stable(read_data_o))
    else $error("result changed under stall");
  // A trap entry lands in supervisor or machine mode.
  a_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_TRAP) |=> (new_privilege_o == PRIV_S ||
                                         new_privilege_o == PRIV_M))
    else $error("bad trap mode");
`endif

endmodule

`default_nettype wire
